>>> hdl/scpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scpc_pkg;

    localparam int UADDR_W = 5;

    // Entry points of the reply program
    localparam logic [UADDR_W-1:0] UA_PROMPT = 5'd0;
    localparam logic [UADDR_W-1:0] UA_ERR    = 5'd3;
    localparam logic [UADDR_W-1:0] UA_GET    = 5'd8;
    localparam logic [UADDR_W-1:0] UA_HEX    = 5'd17;
    localparam logic [UADDR_W-1:0] UA_TAIL   = 5'd18;
    localparam logic [UADDR_W-1:0] UA_OK     = 5'd21;
    localparam logic [UADDR_W-1:0] UA_EMPTY  = 5'd26;

    localparam logic [7:0] CH_0  = 8'h30;
    localparam logic [7:0] CH_1  = 8'h31;
    localparam logic [7:0] CH_3  = 8'h33;
    localparam logic [7:0] CH_9  = 8'h39;
    localparam logic [7:0] CH_EQ = 8'h3D;
    localparam logic [7:0] CH_G  = 8'h67;
    localparam logic [7:0] CH_P  = 8'h70;
    localparam logic [7:0] CH_S  = 8'h73;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    localparam logic [11:0] DUTY_MAX = 12'hFFF;
    localparam logic [7:0]  SEC_MAX  = 8'hFF;

    localparam logic [11:0] RST_OFF_DUTY     = 12'd90;
    localparam logic [11:0] RST_BASE_DUTY    = 12'd110;
    localparam logic [7:0]  RST_DUTY_STEP    = 8'd10;
    localparam logic [7:0]  RST_KILL_SECONDS = 8'd5;

    typedef enum logic [1:0] {
        CFG_OFF_DUTY     = 2'd0,
        CFG_BASE_DUTY    = 2'd1,
        CFG_DUTY_STEP    = 2'd2,
        CFG_KILL_SECONDS = 2'd3
    } t_cfg_addr;

    typedef enum logic [2:0] {
        RP_NONE,
        RP_ERR,
        RP_GET,
        RP_PWM,
        RP_PIN
    } t_reply;

    typedef enum logic [1:0] {
        SRC_NONE,
        SRC_CONST,
        SRC_HEX
    } t_src;

    typedef enum logic [2:0] {
        NX_SEQ,
        NX_JUMP,
        NX_DISPATCH,
        NX_LOOP,
        NX_END
    } t_nxt;

    typedef struct packed {
        logic [7:0]         ch;
        t_src               src;
        t_nxt               nxt;
        logic [UADDR_W-1:0] target;
        logic               info;   // carries the pwm/pin update
    } t_ucode;

    typedef struct packed {
        logic [7:0]  tx_char;
        logic        char_valid;
        logic        last;
        logic        pwm_write;
        logic [1:0]  pwm_channel;
        logic [11:0] pwm_duty;
        logic        pin_write;
        logic [5:0]  pin_index;
        logic        pin_level;
        logic        kill_active;
    } t_result;

    function automatic t_ucode uc(input logic [7:0] ch, input t_src src, input t_nxt nxt,
                                  input logic [UADDR_W-1:0] target, input logic info);
        t_ucode w;
        w.ch     = ch;
        w.src    = src;
        w.nxt    = nxt;
        w.target = target;
        w.info   = info;
        return w;
    endfunction

    function automatic t_ucode ucode_rom(input logic [UADDR_W-1:0] a);
        t_ucode w;
        case (a)
            5'd0:    w = uc(CH_CR, SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd1:    w = uc(CH_LF, SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd2:    w = uc(">",   SRC_CONST, NX_DISPATCH, UA_PROMPT, 1'b0);
            5'd3:    w = uc(CH_CR, SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd4:    w = uc(CH_LF, SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd5:    w = uc("E",   SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd6:    w = uc("R",   SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd7:    w = uc("R",   SRC_CONST, NX_JUMP,     UA_TAIL,   1'b0);
            5'd8:    w = uc(CH_CR, SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd9:    w = uc(CH_LF, SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd10:   w = uc("P",   SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd11:   w = uc("D",   SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd12:   w = uc("S",   SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd13:   w = uc("R",   SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd14:   w = uc("=",   SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd15:   w = uc("0",   SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd16:   w = uc("x",   SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd17:   w = uc(8'h00, SRC_HEX,   NX_LOOP,     UA_PROMPT, 1'b0);
            5'd18:   w = uc(CH_CR, SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd19:   w = uc(CH_LF, SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd20:   w = uc(">",   SRC_CONST, NX_END,      UA_PROMPT, 1'b0);
            5'd21:   w = uc(CH_CR, SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b1);
            5'd22:   w = uc(CH_LF, SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd23:   w = uc("O",   SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd24:   w = uc("K",   SRC_CONST, NX_SEQ,      UA_PROMPT, 1'b0);
            5'd25:   w = uc("!",   SRC_CONST, NX_JUMP,     UA_TAIL,   1'b0);
            default: w = uc(8'h00, SRC_NONE,  NX_END,      UA_PROMPT, 1'b0);
        endcase
        return w;
    endfunction

    function automatic logic [UADDR_W-1:0] reply_entry(input t_reply rp);
        logic [UADDR_W-1:0] a;
        case (rp)
            RP_ERR:  a = UA_ERR;
            RP_GET:  a = UA_GET;
            RP_PWM:  a = UA_OK;
            RP_PIN:  a = UA_OK;
            default: a = UA_EMPTY;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

>>> hdl/scpc_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface scpc_cmd_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  rx_byte;
    logic [31:0] pin_levels;
    modport source (output valid, op, rx_byte, pin_levels, input ready);
    modport sink   (input valid, op, rx_byte, pin_levels, output ready);
endinterface

interface scpc_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tx_char;
    logic        char_valid;
    logic        last;
    logic        pwm_write;
    logic [1:0]  pwm_channel;
    logic [11:0] pwm_duty;
    logic        pin_write;
    logic [5:0]  pin_index;
    logic        pin_level;
    logic        kill_active;
    modport source (output valid, tx_char, char_valid, last, pwm_write, pwm_channel,
                    pwm_duty, pin_write, pin_index, pin_level, kill_active, input ready);
    modport sink   (input valid, tx_char, char_valid, last, pwm_write, pwm_channel,
                    pwm_duty, pin_write, pin_index, pin_level, kill_active, output ready);
endinterface

interface scpc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  addr;
    logic [11:0] data;
    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

>>> hdl/serial_command_pwm_pin_console.sv
// Serial command console with PWM and pin control.
// i_cmd takes one item per received byte (op 0) or one-second tick (op 1).
// Each item produces a run of result items on o_res, one character per
// item; the final one has last set. An item that sends nothing produces a
// single item with char_valid 0. The first item of an OK reply carries the
// PWM or pin update; kill_active is the same on every item of a run.
// i_cfg writes off_duty, base_duty, duty_step, kill_seconds (addr 0..3);
// it is always ready and is meant to be used while the console is idle.
// The command byte is parsed in the accept cycle, then a microcode
// sequencer emits one character per cycle into the output register while
// o_res is not stalled; a run holds 1 to 23 items. The console is ready
// for the next item in the cycle after the last character is loaded, so it
// takes no new item before the current run is through.
// A stall on o_res holds the output register and freezes the sequencer.
// Reset (synchronous, active low) empties the output register, restores the
// register defaults and arms the prompt sent at the start of the next run.
`timescale 1ns / 1ps
`default_nettype none

module serial_command_pwm_pin_console
    import scpc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    scpc_cfg_if.sink   i_cfg,
    scpc_cmd_if.sink   i_cmd,
    scpc_res_if.source o_res
);

    // configuration
    logic [11:0] r_off_duty;
    logic [11:0] r_base_duty;
    logic [7:0]  r_duty_step;
    logic [7:0]  r_kill_seconds;

    // parser state
    logic        r_prompt;
    logic [2:0]  r_byte_pos;
    logic        r_kind;
    logic [5:0]  r_target;
    logic [7:0]  r_seconds;

    // sequencer
    logic               r_busy;
    logic [UADDR_W-1:0] r_pc;
    logic [2:0]         r_hex_cnt;
    t_reply             r_reply;
    logic [31:0]        r_pins;
    logic               r_kill;
    logic [11:0]        r_duty;
    logic               r_pin_level;

    logic    r_out_valid;
    t_result r_out;

    logic cmd_acc;
    logic step_go;

    // parse signals
    logic [2:0]  w_pos;
    logic [7:0]  w_c;
    logic [3:0]  w_dig;
    logic [3:0]  w_val;
    logic [11:0] w_prod;
    logic [12:0] w_sum;
    logic [11:0] w_duty;
    t_reply      n_reply;
    logic [2:0]  n_byte_pos;
    logic        n_kind;
    logic [5:0]  n_target;
    logic [7:0]  n_seconds;

    // sequencer signals
    t_ucode             w_uc;
    logic [3:0]         w_nib;
    logic [7:0]         w_hex;
    logic               w_last;
    logic [UADDR_W-1:0] n_pc;
    logic [2:0]         n_hex_cnt;
    t_result            n_out;

    assign cmd_acc     = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = !r_busy;
    assign i_cfg.ready = 1'b1;
    assign step_go     = r_busy && (!r_out_valid || o_res.ready);

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_duty     <= RST_OFF_DUTY;
            r_base_duty    <= RST_BASE_DUTY;
            r_duty_step    <= RST_DUTY_STEP;
            r_kill_seconds <= RST_KILL_SECONDS;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_addr'(i_cfg.addr))
                CFG_OFF_DUTY:     r_off_duty     <= i_cfg.data;
                CFG_BASE_DUTY:    r_base_duty    <= i_cfg.data;
                CFG_DUTY_STEP:    r_duty_step    <= i_cfg.data[7:0];
                CFG_KILL_SECONDS: r_kill_seconds <= i_cfg.data[7:0];
                default: ;
            endcase
        end
    end

    // ---------------- command parser ----------------
    assign w_c   = i_cmd.rx_byte;
    assign w_pos = r_byte_pos + 3'd1;
    assign w_dig = w_c[3:0];

    always_comb begin
        n_reply    = RP_NONE;
        n_byte_pos = r_byte_pos;
        n_kind     = r_kind;
        n_target   = r_target;
        n_seconds  = r_seconds;
        w_val      = 4'd0;
        if (i_cmd.op) begin
            if (r_seconds != SEC_MAX) begin
                n_seconds = r_seconds + 8'd1;
            end
        end else begin
            n_reply = RP_ERR;
            case (w_pos)
                3'd1: begin
                    if (w_c == CH_G) begin
                        n_reply = RP_GET;
                    end else if (w_c == CH_P) begin
                        n_kind  = 1'b0;
                        n_reply = RP_NONE;
                    end else if (w_c == CH_S) begin
                        n_kind  = 1'b1;
                        n_reply = RP_NONE;
                    end
                end
                3'd2: begin
                    if (w_c inside {[CH_0:CH_3]}) begin
                        // tens digit of a pin number: d*10 = d*8 + d*2
                        n_target = r_kind ? ((6'(w_dig) << 3) + (6'(w_dig) << 1)) : 6'(w_dig);
                        n_reply  = RP_NONE;
                    end
                end
                3'd3: begin
                    if (r_kind && (w_c inside {[CH_0:CH_9]})) begin
                        n_target = r_target + 6'(w_dig);
                        n_reply  = RP_NONE;
                    end else if (!r_kind && w_c == CH_EQ) begin
                        n_reply = RP_NONE;
                    end
                end
                3'd4: begin
                    if (r_kind && w_c == CH_EQ) begin
                        n_reply = RP_NONE;
                    end else if (!r_kind && (w_c inside {[CH_0:CH_9]})) begin
                        w_val   = w_dig;
                        n_reply = RP_PWM;
                    end
                end
                default: begin
                    if (r_kind && (w_c == CH_0 || w_c == CH_1)) begin
                        w_val   = w_dig;
                        n_reply = RP_PIN;
                    end
                end
            endcase
            n_byte_pos = (n_reply == RP_NONE) ? w_pos : 3'd0;
            if (n_reply == RP_PWM) begin
                n_seconds = 8'd0;
            end
        end
    end

    assign w_prod = 12'(w_val) * 12'(r_duty_step);
    assign w_sum  = {1'b0, r_base_duty} + {1'b0, w_prod};
    assign w_duty = (w_val == 4'd0) ? r_off_duty : (w_sum[12] ? DUTY_MAX : w_sum[11:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prompt   <= 1'b1;
            r_byte_pos <= 3'd0;
            r_kind     <= 1'b0;
            r_target   <= 6'd0;
            r_seconds  <= 8'd0;
        end else if (cmd_acc) begin
            r_prompt   <= 1'b0;
            r_byte_pos <= n_byte_pos;
            r_kind     <= n_kind;
            r_target   <= n_target;
            r_seconds  <= n_seconds;
        end
    end

    // run snapshot, taken at accept
    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_reply     <= n_reply;
            r_kill      <= (n_seconds >= r_kill_seconds);
            r_duty      <= w_duty;
            r_pin_level <= w_val[0];
        end
    end

    // ---------------- microcode sequencer ----------------
    assign w_uc  = ucode_rom(r_pc);
    assign w_nib = r_pins[31:28];
    assign w_hex = (w_nib > 4'd9) ? (8'h37 + {4'd0, w_nib}) : (CH_0 + {4'd0, w_nib});

    always_comb begin
        n_pc      = r_pc + 5'd1;
        n_hex_cnt = r_hex_cnt;
        w_last    = 1'b0;
        case (w_uc.nxt)
            NX_SEQ:  n_pc = r_pc + 5'd1;
            NX_JUMP: n_pc = w_uc.target;
            NX_DISPATCH: begin
                n_pc   = reply_entry(r_reply);
                w_last = (r_reply == RP_NONE);
            end
            NX_LOOP: begin
                n_hex_cnt = r_hex_cnt + 3'd1;
                n_pc      = (r_hex_cnt == 3'd7) ? (r_pc + 5'd1) : r_pc;
            end
            NX_END:  w_last = 1'b1;
            default: w_last = 1'b1;
        endcase
    end

    always_comb begin
        n_out.char_valid  = (w_uc.src != SRC_NONE);
        n_out.tx_char     = (w_uc.src == SRC_CONST) ? w_uc.ch :
                            (w_uc.src == SRC_HEX)   ? w_hex   : 8'h00;
        n_out.last        = w_last;
        n_out.pwm_write   = w_uc.info && (r_reply == RP_PWM);
        n_out.pwm_channel = n_out.pwm_write ? r_target[1:0] : 2'd0;
        n_out.pwm_duty    = n_out.pwm_write ? r_duty : 12'd0;
        n_out.pin_write   = w_uc.info && (r_reply == RP_PIN);
        n_out.pin_index   = n_out.pin_write ? r_target : 6'd0;
        n_out.pin_level   = n_out.pin_write && r_pin_level;
        n_out.kill_active = r_kill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_pc      <= UA_PROMPT;
            r_hex_cnt <= 3'd0;
        end else if (cmd_acc) begin
            r_busy    <= 1'b1;
            r_hex_cnt <= 3'd0;
            r_pc      <= r_prompt ? UA_PROMPT : reply_entry(n_reply);
        end else if (step_go) begin
            r_busy    <= !w_last;
            r_pc      <= n_pc;
            r_hex_cnt <= n_hex_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_pins <= i_cmd.pin_levels;
        end else if (step_go && w_uc.src == SRC_HEX) begin
            r_pins <= {r_pins[27:0], 4'd0};
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_go) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.tx_char     = r_out.tx_char;
    assign o_res.char_valid  = r_out.char_valid;
    assign o_res.last        = r_out.last;
    assign o_res.pwm_write   = r_out.pwm_write;
    assign o_res.pwm_channel = r_out.pwm_channel;
    assign o_res.pwm_duty    = r_out.pwm_duty;
    assign o_res.pin_write   = r_out.pin_write;
    assign o_res.pin_index   = r_out.pin_index;
    assign o_res.pin_level   = r_out.pin_level;
    assign o_res.kill_active = r_out.kill_active;

    // ---------------- assertions ----------------
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_go && w_last |=> !r_busy)
        else $error("sequencer still busy after last item");

    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc |=> r_busy && !i_cmd.ready)
        else $error("accepted item did not start a run");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.char_valid |-> r_out.last)
        else $error("item without character is not last");

    a_one_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.pwm_write && r_out.pin_write))
        else $error("pwm and pin update on one item");

    a_hex_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hex_cnt != 3'd0 |-> r_pc == UA_HEX && r_reply == RP_GET)
        else $error("hex digit count outside get reply");

endmodule

`default_nettype wire

>>> bench/scpc_console_checker.sv
`timescale 1ns / 1ps

module scpc_console_checker
    import scpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    scpc_cmd_if  i_cmd,
    scpc_res_if  i_res,
    scpc_cfg_if  i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    // register copies
    logic [11:0] off_duty;
    logic [11:0] base_duty;
    logic [7:0]  duty_step;
    logic [7:0]  kill_seconds;

    // console state
    logic        prompt_due;
    int          byte_pos;
    logic        cmd_is_pin;
    logic [5:0]  target_num;
    logic [7:0]  seconds;

    t_result     run_q[$];
    t_result     tx_expect_q[$];
    int          result_idx;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at result %0d: %s", result_idx, msg);
        o_fail_count++;
    endtask

    task automatic cmp_field(input string name, input logic [31:0] got, input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        end
    endtask

    task automatic add_char(input logic [7:0] ch);
        t_result r;
        r = '0;
        r.tx_char    = ch;
        r.char_valid = 1'b1;
        run_q.push_back(r);
    endtask

    task automatic add_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            add_char(s[i]);
        end
    endtask

    // every reply line starts with CR LF
    task automatic add_line(input string s);
        add_char(CH_CR);
        add_char(CH_LF);
        add_text(s);
    endtask

    task automatic console_step(input logic is_tick, input logic [7:0] c,
                                input logic [31:0] pins);
        t_reply      reply;
        int          pos;
        int          sh;
        int          k;
        int          sum;
        logic [3:0]  val;
        logic [7:0]  d;
        logic [11:0] duty;
        logic        kill;
        t_result     r;

        run_q.delete();
        reply = RP_NONE;
        val   = '0;
        if (prompt_due) begin
            add_line(">");
            prompt_due = 1'b0;
        end

        if (is_tick) begin
            if (seconds != SEC_MAX) seconds = seconds + 8'd1;
        end else begin
            pos   = byte_pos + 1;
            reply = RP_ERR;
            case (pos)
                1: begin
                    if (c == CH_G) begin
                        reply = RP_GET;
                    end else if (c == CH_P) begin
                        cmd_is_pin = 1'b0;
                        reply      = RP_NONE;
                    end else if (c == CH_S) begin
                        cmd_is_pin = 1'b1;
                        reply      = RP_NONE;
                    end
                end
                2: begin
                    if (c >= CH_0 && c <= CH_3) begin
                        target_num = cmd_is_pin ? 6'((c - CH_0) * 10) : 6'(c - CH_0);
                        reply      = RP_NONE;
                    end
                end
                3: begin
                    if (cmd_is_pin && c >= CH_0 && c <= CH_9) begin
                        target_num = 6'(target_num + (c - CH_0));
                        reply      = RP_NONE;
                    end else if (!cmd_is_pin && c == CH_EQ) begin
                        reply = RP_NONE;
                    end
                end
                4: begin
                    if (cmd_is_pin && c == CH_EQ) begin
                        reply = RP_NONE;
                    end else if (!cmd_is_pin && c >= CH_0 && c <= CH_9) begin
                        val   = 4'(c - CH_0);
                        reply = RP_PWM;
                    end
                end
                default: begin
                    if (cmd_is_pin && (c == CH_0 || c == CH_1)) begin
                        val   = 4'(c - CH_0);
                        reply = RP_PIN;
                    end
                end
            endcase
            byte_pos = (reply == RP_NONE) ? pos : 0;
        end

        case (reply)
            RP_ERR: add_line("ERR");
            RP_GET: begin
                add_line("PDSR=0x");
                for (sh = 28; sh >= 0; sh -= 4) begin
                    d = 8'(pins[sh +: 4]) + CH_0;
                    if (d > CH_9) d = d + 8'd7;
                    add_char(d);
                end
            end
            RP_PWM, RP_PIN: begin
                r = '0;
                r.tx_char    = CH_CR;
                r.char_valid = 1'b1;
                if (reply == RP_PWM) begin
                    if (val == 4'd0) begin
                        duty = off_duty;
                    end else begin
                        sum  = int'(base_duty) + int'(val) * int'(duty_step);
                        duty = (sum > int'(DUTY_MAX)) ? DUTY_MAX : 12'(sum);
                    end
                    seconds       = '0;
                    r.pwm_write   = 1'b1;
                    r.pwm_channel = target_num[1:0];
                    r.pwm_duty    = duty;
                end else begin
                    r.pin_write = 1'b1;
                    r.pin_index = target_num;
                    r.pin_level = val[0];
                end
                run_q.push_back(r);
                add_char(CH_LF);
                add_text("OK!");
            end
            default: ;
        endcase
        if (reply != RP_NONE) add_line(">");

        // nothing sent: one empty item still closes the run
        if (run_q.size() == 0) run_q.push_back('0);

        kill = (seconds >= kill_seconds);
        for (k = 0; k < run_q.size(); k++) begin
            r             = run_q[k];
            r.kill_active = kill;
            r.last        = (k == run_q.size() - 1);
            tx_expect_q.push_back(r);
        end
    endtask

    task automatic check_result();
        t_result want;
        if (tx_expect_q.size() == 0) begin
            report_mismatch($sformatf("item with nothing expected, char %0h", i_res.tx_char));
        end else begin
            want = tx_expect_q.pop_front();
            cmp_field("tx_char",     i_res.tx_char,     want.tx_char);
            cmp_field("char_valid",  i_res.char_valid,  want.char_valid);
            cmp_field("last",        i_res.last,        want.last);
            cmp_field("pwm_write",   i_res.pwm_write,   want.pwm_write);
            cmp_field("pwm_channel", i_res.pwm_channel, want.pwm_channel);
            cmp_field("pwm_duty",    i_res.pwm_duty,    want.pwm_duty);
            cmp_field("pin_write",   i_res.pin_write,   want.pin_write);
            cmp_field("pin_index",   i_res.pin_index,   want.pin_index);
            cmp_field("pin_level",   i_res.pin_level,   want.pin_level);
            cmp_field("kill_active", i_res.kill_active, want.kill_active);
        end
        result_idx++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            off_duty     = RST_OFF_DUTY;
            base_duty    = RST_BASE_DUTY;
            duty_step    = RST_DUTY_STEP;
            kill_seconds = RST_KILL_SECONDS;
            prompt_due   = 1'b1;
            byte_pos     = 0;
            cmd_is_pin   = 1'b0;
            target_num   = '0;
            seconds      = '0;
            tx_expect_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_addr'(i_cfg.addr))
                    CFG_OFF_DUTY:     off_duty     = i_cfg.data;
                    CFG_BASE_DUTY:    base_duty    = i_cfg.data;
                    CFG_DUTY_STEP:    duty_step    = i_cfg.data[7:0];
                    CFG_KILL_SECONDS: kill_seconds = i_cfg.data[7:0];
                    default: ;
                endcase
            end
            if (i_cmd.valid && i_cmd.ready) begin
                console_step(i_cmd.op, i_cmd.rx_byte, i_cmd.pin_levels);
            end
            if (i_res.valid && i_res.ready) begin
                check_result();
            end
        end
        o_pending = tx_expect_q.size();
    end

endmodule

>>> bench/serial_command_pwm_pin_console_tb.sv
`timescale 1ns / 1ps

module serial_command_pwm_pin_console_tb
    import scpc_pkg::*;
();

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam int RAND_ITEMS   = 245;
    localparam int HOLD_AT      = 225;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;

    logic i_clk;
    logic i_rst_n;

    int   fail_count;
    int   pending_count;
    int   sent_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   cycle_count;
    bit   hold_done;

    scpc_cmd_if cmd_if ();
    scpc_res_if res_if ();
    scpc_cfg_if cfg_if ();

    serial_command_pwm_pin_console u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    scpc_console_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd_if),
        .i_res        (res_if),
        .i_cfg        (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // offers one item after a random gap and returns at the edge it is taken
    task automatic send_item(input logic op, input logic [7:0] ch, input logic [31:0] pins);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.op         <= op;
        cmd_if.rx_byte    <= ch;
        cmd_if.pin_levels <= pins;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            send_item(OP_BYTE, s[i], $urandom());
        end
    endtask

    task automatic write_reg(input t_cfg_addr a, input logic [11:0] d);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= a;
        cfg_if.data  <= d;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apply_setting(input logic [11:0] off, input logic [11:0] base,
                                 input logic [7:0] step, input logic [7:0] kill);
        write_reg(CFG_OFF_DUTY, off);
        write_reg(CFG_BASE_DUTY, base);
        write_reg(CFG_DUTY_STEP, {4'd0, step});
        write_reg(CFG_KILL_SECONDS, {4'd0, kill});
    endtask

    task automatic drain_console();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // mostly well-formed commands with random content, some ticks and broken ones
    task automatic send_random_command();
        logic [7:0] seq [5];
        int         len;
        int         pick;
        int         cut;
        int         k;
        pick = $urandom_range(99);
        len  = 0;
        if (pick < 10) begin
            repeat ($urandom_range(3, 1)) send_item(OP_TICK, 8'($urandom()), $urandom());
        end else begin
            if (pick < 20) begin
                seq[0] = CH_G;
                len    = 1;
            end else if (pick < 55 || (pick >= 85 && pick < 92)) begin
                seq[0] = CH_P;
                seq[1] = CH_0 + 8'($urandom_range(3));
                seq[2] = CH_EQ;
                seq[3] = CH_0 + 8'($urandom_range(9));
                len    = 4;
            end else begin
                seq[0] = CH_S;
                seq[1] = CH_0 + 8'($urandom_range(3));
                seq[2] = CH_0 + 8'($urandom_range(9));
                seq[3] = CH_EQ;
                seq[4] = CH_0 + 8'($urandom_range(1));
                len    = 5;
            end
            if (pick >= 85) begin
                cut      = $urandom_range(len - 1);
                seq[cut] = 8'($urandom());
                len      = cut + 1;
            end
            for (k = 0; k < len; k++) begin
                // a tick in mid-command must not disturb parsing
                if ($urandom_range(19) == 0) send_item(OP_TICK, 8'($urandom()), $urandom());
                send_item(OP_BYTE, seq[k], $urandom());
            end
        end
    endtask

    initial begin
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && sent_count >= HOLD_AT) begin
                res_if.ready <= 1'b0;
                hold_done = 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int seg;
        int rand_base;
        int n;

        sent_count    = 0;
        hold_done     = 1'b0;
        send_idle_pct = 9;
        recv_idle_pct = 55;
        i_rst_n           <= 1'b0;
        cmd_if.valid      <= 1'b0;
        cmd_if.op         <= OP_BYTE;
        cmd_if.rx_byte    <= '0;
        cmd_if.pin_levels <= '0;
        cfg_if.valid      <= 1'b0;
        cfg_if.addr       <= CFG_OFF_DUTY;
        cfg_if.data       <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // prompt goes out ahead of the first reply
        send_item(OP_BYTE, CH_G, 32'h0000_0000);
        // tick with no prompt due: empty run
        send_item(OP_TICK, 8'h00, 32'h0000_0000);
        send_item(OP_BYTE, CH_G, 32'hFFFF_FFFF);
        send_text("p3=9");
        send_text("s39=1");
        send_item(OP_BYTE, 8'hFF, $urandom());
        send_text("p0=0");
        send_text("s0x");
        // reach the kill limit
        repeat (5) send_item(OP_TICK, 8'hFF, $urandom());

        rand_base = sent_count;
        for (seg = 0; seg < 4; seg++) begin
            drain_console();
            case (seg)
                0: apply_setting(12'd0, DUTY_MAX, 8'hFF, 8'd0);
                1: apply_setting(DUTY_MAX, 12'd0, 8'd0, SEC_MAX);
                2: apply_setting(12'($urandom()), 12'($urandom()), 8'($urandom()),
                                 8'($urandom_range(6, 1)));
                default: apply_setting(12'($urandom()), 12'($urandom_range(4095, 2000)),
                                       8'($urandom_range(255, 100)), 8'($urandom_range(4, 2)));
            endcase
            while (sent_count - rand_base < RAND_ITEMS * (seg + 1) / 4) begin
                n = sent_count - rand_base;
                if (n < 90) begin
                    send_idle_pct = 9;
                    recv_idle_pct = 55;
                end else if (n < 180) begin
                    send_idle_pct = 55;
                    recv_idle_pct = 9;
                end else begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                send_random_command();
            end
        end
        drain_console();

        if (fail_count == 0 && pending_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
